FILE: src/sv39m_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39m_pkg
// Shared types and codes of the Sv39 page-table map engine.
// ---------------------------------------------------------------------------
package sv39m_pkg;

  localparam int PpnW    = 44;
  localparam int VaW     = 39;
  localparam int PaW     = 56;
  localparam int EntryW  = 52;
  localparam int VpnW    = 9;
  localparam int CmdW    = 3;
  localparam int StatW   = 3;
  localparam int CfgIdxW = 2;

  // Flag bits of an entry.
  localparam logic [7:0] FlV = 8'h01;
  localparam logic [7:0] FlR = 8'h02;
  localparam logic [7:0] FlW = 8'h04;
  localparam logic [7:0] FlU = 8'h10;
  localparam logic [7:0] FlA = 8'h40;
  localparam logic [7:0] FlD = 8'h80;

  typedef enum logic [CmdW-1:0] {
    CMD_MAP   = 3'd0,
    CMD_FAULT = 3'd1,
    CMD_SETFL = 3'd2,
    CMD_ALLOC = 3'd3,
    CMD_FREE  = 3'd4
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_NOTMAP  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_FOREIGN = 3'd4,
    ST_BADCMD  = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RAM_BASE   = 2'd0,
    REG_USER_START = 2'd1,
    REG_USER_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK_CHK,
    S_POP_RD,
    S_POP_WAIT,
    S_CLEAR,
    S_LINK,
    S_LEAF_RD,
    S_LEAF_WR,
    S_PUSH,
    S_DONE
  } fsm_t;

endpackage
`default_nettype wire

FILE: src/sv39m_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39m_in_if
// Command channel: valid, ready and one command word.
// ---------------------------------------------------------------------------
interface sv39m_in_if;
  logic                          valid;
  logic                          ready;
  logic [sv39m_pkg::CmdW-1:0]    command;
  logic [sv39m_pkg::VaW-1:0]     vaddr;
  logic [7:0]                    flags;
  logic [sv39m_pkg::PpnW-1:0]    phys_page;
  modport source (output valid, command, vaddr, flags, phys_page, input ready);
  modport sink   (input valid, command, vaddr, flags, phys_page, output ready);
endinterface
`default_nettype wire

FILE: src/sv39m_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39m_out_if
// Result channel: valid, ready and one result word.
// ---------------------------------------------------------------------------
interface sv39m_out_if;
  logic                          valid;
  logic                          ready;
  logic [sv39m_pkg::StatW-1:0]   status;
  logic [sv39m_pkg::PaW-1:0]     phys_addr;
  logic [7:0]                    entry_flags;
  modport source (output valid, status, phys_addr, entry_flags, input ready);
  modport sink   (input valid, status, phys_addr, entry_flags, output ready);
endinterface
`default_nettype wire

FILE: src/sv39m_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39m_cfg_if
// Register write channel: valid, ready, register index and write data.
// ---------------------------------------------------------------------------
interface sv39m_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sv39m_pkg::CfgIdxW-1:0]   index;
  logic [sv39m_pkg::PpnW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/sv39m_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39m_ram
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module sv39m_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle; read data appears in the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: src/sv39_page_table_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sv39_page_table_map_engine
// Sv39 page-table builder over a pool of pages with a linked free list.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one command word (map, fault map, set flags, alloc, free);
//   every command gives exactly one word on out_ch. cfg_ch writes the pool
//   base and user range; it is always ready. Write it only while idle; the block does not enforce this.
// Memory: the single-port entry memory takes one access per cycle. A map
//   that creates a table page pops it off the free list, zeroes its 512
//   entries and then writes the link entry that points to it.
// Throughput: one command at a time; the next word is taken as soon as the
//   engine is back in idle, even while the last result still waits.
// Reset: a clearing pass writes all NUM_PAGES*512 entries to zero and builds
//   the free list; no command is taken during it.
// Stall: a result is held in the output register until out_ch takes it; a
//   finished command whose result cannot yet be stored waits in place.
// ---------------------------------------------------------------------------
module sv39_page_table_map_engine #(
  parameter int NUM_PAGES       = 64,
  parameter int FIRST_FREE_PAGE = 1,
  parameter int ROOT_PAGE       = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sv39m_in_if.sink   in_ch,
  sv39m_out_if.source out_ch,
  sv39m_cfg_if.sink  cfg_ch
);

  import sv39m_pkg::*;

  localparam int PW       = $clog2(NUM_PAGES);
  localparam int CW       = $clog2(NUM_PAGES + 1);
  localparam int AW       = PW + VpnW;
  localparam int Depth    = NUM_PAGES * 512;
  localparam int RootIdx  = ROOT_PAGE % NUM_PAGES;
  localparam int RawHead  = (FIRST_FREE_PAGE == RootIdx) ? FIRST_FREE_PAGE + 1
                                                         : FIRST_FREE_PAGE;
  localparam int InitHead = (RawHead < NUM_PAGES) ? RawHead : 0;
  localparam int InitCnt  = (FIRST_FREE_PAGE >= NUM_PAGES) ? 0 :
                            NUM_PAGES - FIRST_FREE_PAGE -
                            ((RootIdx >= FIRST_FREE_PAGE) ? 1 : 0);

  // Registers.
  fsm_t              state_r, state_nxt;
  logic [AW-1:0]     init_r, init_nxt;
  logic [PpnW-1:0]   base_r;
  logic [26:0]       ustart_r;
  logic [27:0]       uend_r;
  cmd_t              cmd_r, cmd_nxt;
  logic [CmdW-1:0]   raw_cmd_r, raw_cmd_nxt;
  logic [VaW-1:0]    va_r, va_nxt;
  logic [7:0]        fl_r, fl_nxt;
  logic [PpnW-1:0]   pp_r, pp_nxt;
  logic              lvl2_r, lvl2_nxt;
  logic              miss_r, miss_nxt;
  logic [PW-1:0]     pt_r, pt_nxt;
  logic [PW-1:0]     new_r, new_nxt;
  logic [VpnW-1:0]   clr_r, clr_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [StatW-1:0]  rst_stat_r, rst_stat_nxt;
  logic [PaW-1:0]    res_pa_r, res_pa_nxt;
  logic [7:0]        res_ef_r, res_ef_nxt;
  logic              out_valid_r;
  logic [StatW-1:0]  out_stat_r;
  logic [PaW-1:0]    out_pa_r;
  logic [7:0]        out_ef_r;

  // Memory ports.
  logic              pte_we;
  logic [AW-1:0]     pte_addr;
  logic [EntryW-1:0] pte_wdata, pte_rdata;
  logic              nf_we;
  logic [PW-1:0]     nf_addr, nf_wdata, nf_rdata;

  // Shared datapath terms.
  logic [VpnW-1:0]   vpn_lvl;
  logic [PpnW-1:0]   walk_off, pp_off, new_ppn;
  logic              walk_in_pool, pp_in_pool, pool_empty;
  logic [26:0]       va_vpn;
  logic              in_range;
  logic [PW+1:0]     link_a, link_b;
  logic [PW-1:0]     init_link;
  logic              init_last;
  logic [EntryW-1:0] leaf_e;
  logic [7:0]        leaf_fl;
  logic              out_free;

  sv39m_ram #(.Width(EntryW), .Depth(Depth)) u_pte_ram (
    .clk(clk), .we(pte_we), .addr(pte_addr), .wdata(pte_wdata), .rdata(pte_rdata)
  );

  sv39m_ram #(.Width(PW), .Depth(NUM_PAGES)) u_nf_ram (
    .clk(clk), .we(nf_we), .addr(nf_addr), .wdata(nf_wdata), .rdata(nf_rdata)
  );

  // Walk, pool and range terms.
  always_comb begin
    vpn_lvl      = lvl2_r ? va_r[38:30] : va_r[29:21];
    walk_off     = pte_rdata[EntryW-1:8] - base_r;
    walk_in_pool = (walk_off < PpnW'(NUM_PAGES));
    pp_off       = pp_r - base_r;
    pp_in_pool   = (pp_off < PpnW'(NUM_PAGES));
    new_ppn      = base_r + PpnW'(new_r);
    pool_empty   = (cnt_r == '0);
    va_vpn       = va_r[38:12];
    in_range     = (va_vpn >= ustart_r) && ({1'b0, va_vpn} + 28'd1 <= uend_r);
    out_free     = !out_valid_r || out_ch.ready;
    init_last    = (init_r == AW'(Depth - 1));
  end

  // Reset link of each page: the next page above it, skipping the root.
  always_comb begin
    link_a = (PW+2)'(init_r[PW-1:0]) + (PW+2)'(1);
    link_b = (link_a == (PW+2)'(RootIdx)) ? link_a + (PW+2)'(1) : link_a;
    init_link = (link_b >= (PW+2)'(NUM_PAGES)) ? '0 : link_b[PW-1:0];
  end

  // Leaf entry after map or set flags.
  always_comb begin
    if (cmd_r == CMD_SETFL) begin
      leaf_fl = fl_r | FlV | FlA | FlD;
      leaf_e  = {pte_rdata[EntryW-1:8], leaf_fl};
    end else begin
      leaf_fl = pte_rdata[7:0] | FlV | FlA | FlD | fl_r;
      leaf_e  = {new_ppn, leaf_fl};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:     if (init_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_ch.valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (raw_cmd_r)
          CMD_MAP, CMD_SETFL: state_nxt = S_WALK_RD;
          CMD_FAULT: state_nxt = in_range ? S_WALK_RD : S_DONE;
          CMD_ALLOC: state_nxt = pool_empty ? S_DONE : S_POP_RD;
          CMD_FREE:  state_nxt = pp_in_pool ? S_PUSH : S_DONE;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_WALK_RD:  state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (pte_rdata[0]) begin
          if (!walk_in_pool) state_nxt = S_DONE;
          else if (lvl2_r) state_nxt = S_WALK_RD;
          else if (cmd_r == CMD_SETFL) state_nxt = S_LEAF_RD;
          else state_nxt = pool_empty ? S_DONE : S_POP_RD;
        end else begin
          if (cmd_r == CMD_SETFL || pool_empty) state_nxt = S_DONE;
          else state_nxt = S_POP_RD;
        end
      end
      S_POP_RD:   state_nxt = S_POP_WAIT;
      S_POP_WAIT: begin
        if (cmd_r == CMD_ALLOC) state_nxt = S_DONE;
        else if (miss_r) state_nxt = S_CLEAR;
        else state_nxt = S_LEAF_RD;
      end
      S_CLEAR:    if (clr_r == '1) state_nxt = S_LINK;
      S_LINK: begin
        if (lvl2_r) state_nxt = S_WALK_RD;
        else state_nxt = pool_empty ? S_DONE : S_POP_RD;
      end
      S_LEAF_RD:  state_nxt = S_LEAF_WR;
      S_LEAF_WR:  state_nxt = S_DONE;
      S_PUSH:     state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result terms.
  always_comb begin
    init_nxt     = init_r;
    cmd_nxt      = cmd_r;
    raw_cmd_nxt  = raw_cmd_r;
    va_nxt       = va_r;
    fl_nxt       = fl_r;
    pp_nxt       = pp_r;
    lvl2_nxt     = lvl2_r;
    miss_nxt     = miss_r;
    pt_nxt       = pt_r;
    new_nxt      = new_r;
    clr_nxt      = clr_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    rst_stat_nxt = rst_stat_r;
    res_pa_nxt   = res_pa_r;
    res_ef_nxt   = res_ef_r;
    pte_we       = 1'b0;
    pte_addr     = {pt_r, vpn_lvl};
    pte_wdata    = '0;
    nf_we        = 1'b0;
    nf_addr      = head_r;
    nf_wdata     = head_r;
    case (state_r)
      S_INIT: begin
        pte_we    = 1'b1;
        pte_addr  = init_r;
        nf_we     = (init_r[AW-1:PW] == '0);
        nf_addr   = init_r[PW-1:0];
        nf_wdata  = init_link;
        init_nxt  = init_r + AW'(1);
      end
      S_IDLE: begin
        raw_cmd_nxt = in_ch.command;
        cmd_nxt     = cmd_t'(in_ch.command);
        va_nxt      = in_ch.vaddr;
        fl_nxt      = in_ch.flags;
        pp_nxt      = in_ch.phys_page;
        lvl2_nxt    = 1'b1;
        miss_nxt    = 1'b0;
        pt_nxt      = PW'(RootIdx);
        clr_nxt     = '0;
        rst_stat_nxt = ST_OK;
        res_pa_nxt  = '0;
        res_ef_nxt  = '0;
      end
      S_DECODE: begin
        case (raw_cmd_r)
          CMD_MAP, CMD_SETFL: ;
          CMD_FAULT: begin
            // A fault maps the whole page as user read/write.
            if (in_range) begin
              cmd_nxt         = CMD_MAP;
              va_nxt[11:0]    = '0;
              fl_nxt          = FlR | FlW | FlU;
            end else begin
              rst_stat_nxt = ST_RANGE;
            end
          end
          CMD_ALLOC: if (pool_empty) rst_stat_nxt = ST_NOFREE;
          CMD_FREE: begin
            if (pp_in_pool) new_nxt = pp_off[PW-1:0];
            else rst_stat_nxt = ST_FOREIGN;
          end
          default: rst_stat_nxt = ST_BADCMD;
        endcase
      end
      S_WALK_CHK: begin
        if (pte_rdata[0]) begin
          if (!walk_in_pool) begin
            rst_stat_nxt = ST_FOREIGN;
          end else begin
            pt_nxt   = walk_off[PW-1:0];
            lvl2_nxt = 1'b0;
            if (!lvl2_r && cmd_r != CMD_SETFL && pool_empty) rst_stat_nxt = ST_NOFREE;
          end
        end else begin
          miss_nxt = 1'b1;
          if (cmd_r == CMD_SETFL) rst_stat_nxt = ST_NOTMAP;
          else if (pool_empty) rst_stat_nxt = ST_NOFREE;
        end
      end
      S_POP_RD: begin
        new_nxt = head_r;
      end
      S_POP_WAIT: begin
        head_nxt = nf_rdata;
        cnt_nxt  = cnt_r - CW'(1);
        if (cmd_r == CMD_ALLOC) res_pa_nxt = {new_ppn, 12'h000};
      end
      S_CLEAR: begin
        // Zero the fresh table page, one entry a cycle.
        pte_we    = 1'b1;
        pte_addr  = {new_r, clr_r};
        clr_nxt   = clr_r + VpnW'(1);
      end
      S_LINK: begin
        pte_we    = 1'b1;
        pte_wdata = {new_ppn, FlV};
        pt_nxt    = new_r;
        miss_nxt  = 1'b0;
        lvl2_nxt  = 1'b0;
        if (!lvl2_r && pool_empty) rst_stat_nxt = ST_NOFREE;
      end
      S_LEAF_RD: begin
        pte_addr = {pt_r, va_r[20:12]};
      end
      S_LEAF_WR: begin
        pte_we     = 1'b1;
        pte_addr   = {pt_r, va_r[20:12]};
        pte_wdata  = leaf_e;
        res_pa_nxt = {leaf_e[EntryW-1:8], va_r[11:0]};
        res_ef_nxt = leaf_fl;
      end
      S_PUSH: begin
        nf_we    = 1'b1;
        nf_addr  = new_r;
        nf_wdata = head_r;
        head_nxt = new_r;
        if (cnt_r < CW'(NUM_PAGES)) cnt_nxt = cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  // State and work registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      head_r  <= PW'(InitHead);
      cnt_r   <= CW'(InitCnt);
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    raw_cmd_r  <= raw_cmd_nxt;
    va_r       <= va_nxt;
    fl_r       <= fl_nxt;
    pp_r       <= pp_nxt;
    lvl2_r     <= lvl2_nxt;
    miss_r     <= miss_nxt;
    pt_r       <= pt_nxt;
    new_r      <= new_nxt;
    clr_r      <= clr_nxt;
    rst_stat_r <= rst_stat_nxt;
    res_pa_r   <= res_pa_nxt;
    res_ef_r   <= res_ef_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= PpnW'(524288);
      ustart_r <= 27'd786432;
      uend_r   <= 28'd1048576;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_RAM_BASE:   base_r   <= cfg_ch.data;
        REG_USER_START: ustart_r <= cfg_ch.data[26:0];
        REG_USER_END:   uend_r   <= cfg_ch.data[27:0];
        default: ;
      endcase
    end
  end

  // Output register; an error result carries zero address and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_stat_r <= rst_stat_r;
      out_pa_r   <= (rst_stat_r == ST_OK) ? res_pa_r : '0;
      out_ef_r   <= (rst_stat_r == ST_OK) ? res_ef_r : '0;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.phys_addr   = out_pa_r;
  assign out_ch.entry_flags = out_ef_r;

`ifndef NO_ASSERTIONS
  // The free count never passes the pool size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_PAGES)) else $error("free count above pool size");

  // An accepted command always leaves idle.
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_DECODE)
    else $error("accepted command not decoded");

  // Neither the entry store nor the free list is written while idle or waiting to deliver.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !pte_we && !nf_we)
    else $error("memory write outside a command");

  // A pop never happens on an empty pool.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_RD |-> cnt_r != '0) else $error("pop from empty pool");
`endif

endmodule
`default_nettype wire
